/* rtl/kre_pkg.sv */
// ----------------------------------------------------------------------------
// kre_pkg
// Shared constants, types and fixed-point helpers of the roll estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package kre_pkg;

  localparam int FRAC_BITS       = 28;
  localparam int ATAN_ITERATIONS = 24;
  localparam int ATAN_SHIFT      = 30 - FRAC_BITS;
  localparam int GYRO_SHIFT      = 40 - FRAC_BITS;
  localparam int ITER_W          = $clog2(ATAN_ITERATIONS + 1);

  // CORDIC working widths: 17-bit sum times 31-bit scale, plus growth room
  localparam int ACC_W = 48;
  localparam int CRD_W = 51;
  localparam int ANG_W = 34;

  // divider: |num| shifted up by FRAC_BITS
  localparam int DVD_W = 32 + FRAC_BITS;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam logic signed [63:0] Q_NOISE_ANGLE = 64'((ONE_Q * 1 + 500) / 1000);
  localparam logic signed [63:0] Q_NOISE_BIAS  = 64'((ONE_Q * 3 + 500) / 1000);
  localparam logic signed [63:0] Q_NOISE_MEAS  = 64'((ONE_Q * 3 + 50) / 100);

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam longint ATAN_TAB [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021687, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2, 1, 0
  };

  typedef enum logic [2:0] {
    REG_ACCEL_Y_OFFSET = 3'd0,
    REG_ACCEL_Z_OFFSET = 3'd1,
    REG_GYRO_X_OFFSET  = 3'd2,
    REG_ACCEL_SCALE    = 3'd3,
    REG_GYRO_SCALE     = 3'd4,
    REG_SAMPLE_PERIOD  = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_AY  = 5'd0,
    OP_AZ  = 5'd1,
    OP_GX  = 5'd2,
    OP_BT  = 5'd3,
    OP_PT  = 5'd4,
    OP_PRE = 5'd5,
    OP_CAA = 5'd6,
    OP_CBB = 5'd7,
    OP_K0  = 5'd8,
    OP_K1  = 5'd9,
    OP_VAR = 5'd10,
    OP_UA  = 5'd11,
    OP_UB  = 5'd12,
    OP_UBA = 5'd13,
    OP_UBB = 5'd14,
    OP_UAA = 5'd15,
    OP_UAB = 5'd16
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [63:0] qround(input logic signed [63:0] p);
    return (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [ANG_W-1:0] atan_q(input logic [4:0] k);
    longint v;
    v = ATAN_TAB[k];
    if (ATAN_SHIFT == 0) return ANG_W'(v);
    return ANG_W'((v + (longint'(1) << (ATAN_SHIFT - 1))) >>> ATAN_SHIFT);
  endfunction

  localparam logic signed [ANG_W-1:0] HALF_PI_Q = (ATAN_SHIFT == 0) ?
    ANG_W'(HALF_PI_Q30) :
    ANG_W'((HALF_PI_Q30 + (longint'(1) << (ATAN_SHIFT - 1))) >>> ATAN_SHIFT);

endpackage

`default_nettype wire

/* rtl/kalman_roll_estimator_unit.sv */
// ----------------------------------------------------------------------------
// kalman_roll_estimator_unit
// Roll estimator: raw IMU sample in (calibrated here), Kalman-filtered roll and gyro
// bias out, on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* takes one word {gyro X, accel Z, accel Y} of raw 16-bit counts.
//  - out_* gives one word {bias estimate, roll angle}, both Q4.28, per input.
//  - cfg_* writes calibration offsets and scales; cfg_ready is always high.
//    Write only while no sample is in flight.
//  - Per item, two gain divisions (60 quotient steps each) dominate the work,
//    plus 13 multiplies. When the innovation variance is not positive each
//    division skips its quotient steps and gives zero. The atan2 CORDIC
//    (24 steps) overlaps with the multiplies.
//  - in_tready is high only while the sequencer is idle, one sample at a
//    time; a new sample waits until the sequencer is through with the last.
//  - The result sits in an output register; a new sample may be taken while
//    it waits. If the receiver still stalls when the next result is ready,
//    the sequencer holds it until the register frees up.
//  - Reset clears filter state and covariance to zero and loads default
//    calibration values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_roll_estimator_unit import kre_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,    // raw_accel_y, raw_accel_z, raw_gyro_x
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,   // roll_angle, bias_estimate
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_WB   = 7'b0000100,
    S_ALU  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_DIVW = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic signed [15:0] accel_y_offset_r, accel_z_offset_r, gyro_x_offset_r;
  logic [30:0]        accel_scale_r, gyro_scale_r, sample_period_r;

  logic signed [31:0] angle_r, bias_r, cov_aa_r, cov_ab_r, cov_ba_r, cov_bb_r;
  logic signed [16:0] sy_r, sz_r, sg_r;
  logic signed [ACC_W-1:0] ay_r;
  logic signed [31:0] gx_r, pt_r, tmp_r, k0_r, k1_r, var_r;

  logic               out_tvalid_r;
  logic [63:0]        out_tdata_r;

  logic signed [31:0] mul_a, mul_b, tper;
  logic signed [63:0] prod, prod_q;
  logic               cor_start, cor_done, div_start, div_done, adv, load;
  logic signed [ANG_W-1:0] roll;
  logic signed [31:0] div_num, div_q;
  logic signed [ANG_W-1:0] div_den;
  logic               in_acc;

  function automatic state_t op_state(input op_t o);
    unique case (o) inside
      OP_PRE, OP_VAR: return S_ALU;
      OP_K0, OP_K1:   return S_DIV;
      default:        return S_MUL;
    endcase
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign tper      = 32'({1'b0, sample_period_r});

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_y_offset_r <= '0;
      accel_z_offset_r <= '0;
      gyro_x_offset_r  <= '0;
      accel_scale_r    <= 31'd16384;
      gyro_scale_r     <= 31'd1464900;
      sample_period_r  <= 31'd2684355;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACCEL_Y_OFFSET: accel_y_offset_r <= cfg_data[15:0];
        REG_ACCEL_Z_OFFSET: accel_z_offset_r <= cfg_data[15:0];
        REG_GYRO_X_OFFSET:  gyro_x_offset_r  <= cfg_data[15:0];
        REG_ACCEL_SCALE:    accel_scale_r    <= cfg_data[30:0];
        REG_GYRO_SCALE:     gyro_scale_r     <= cfg_data[30:0];
        REG_SAMPLE_PERIOD:  sample_period_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_AY:  begin mul_a = 32'(sy_r);   mul_b = 32'({1'b0, accel_scale_r}); end
      OP_AZ:  begin mul_a = 32'(sz_r);   mul_b = 32'({1'b0, accel_scale_r}); end
      OP_GX:  begin mul_a = 32'(sg_r);   mul_b = 32'({1'b0, gyro_scale_r});  end
      OP_BT:  begin mul_a = bias_r;      mul_b = tper;     end
      OP_PT:  begin mul_a = tper;        mul_b = cov_bb_r; end
      OP_CAA: begin mul_a = tper;        mul_b = tmp_r;    end
      OP_CBB: begin mul_a = 32'(Q_NOISE_BIAS); mul_b = tper; end
      OP_UA:  begin mul_a = k0_r;        mul_b = var_r;    end
      OP_UB:  begin mul_a = k1_r;        mul_b = var_r;    end
      OP_UBA: begin mul_a = k1_r;        mul_b = cov_aa_r; end
      OP_UBB: begin mul_a = k1_r;        mul_b = cov_ab_r; end
      OP_UAA: begin mul_a = k0_r;        mul_b = cov_aa_r; end
      OP_UAB: begin mul_a = k0_r;        mul_b = cov_ab_r; end
      default: ;
    endcase
  end

  kre_mul u_mul (
    .clk (clk),
    .en  (state_r == S_MUL),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod),
    .p_q (prod_q)
  );

  assign cor_start = (state_r == S_WB) && (op_r == OP_AZ);

  kre_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (prod[ACC_W-1:0]),
    .y_in  (ay_r),
    .done  (cor_done),
    .angle (roll)
  );

  assign div_start = (state_r == S_DIV);
  assign div_num   = (op_r == OP_K0) ? cov_aa_r : cov_ba_r;
  assign div_den   = ANG_W'(cov_aa_r) + ANG_W'(Q_NOISE_MEAS);

  kre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // sequencer
  always_comb begin
    adv = 1'b0;
    unique case (state_r)
      S_WB:    adv = 1'b1;
      S_ALU:   adv = (op_r != OP_VAR) || cor_done;
      S_DIVW:  adv = div_done;
      default: adv = 1'b0;
    endcase
  end

  assign load = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_MUL;
          op_nxt    = OP_AY;
        end
      end
      S_MUL: state_nxt = S_WB;
      S_DIV: state_nxt = S_DIVW;
      S_WB, S_ALU, S_DIVW: begin
        if (adv) begin
          op_nxt    = op_t'(op_r + 5'd1);
          state_nxt = (op_r == OP_UAB) ? S_DONE : op_state(op_t'(op_r + 5'd1));
        end
      end
      S_DONE: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_AY;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // filter state and temporaries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r  <= '0;
      bias_r   <= '0;
      cov_aa_r <= '0;
      cov_ab_r <= '0;
      cov_ba_r <= '0;
      cov_bb_r <= '0;
    end else begin
      if (in_acc) begin
        sy_r <= 17'(signed'(in_tdata[15:0]))  + 17'(accel_y_offset_r);
        sz_r <= 17'(signed'(in_tdata[31:16])) + 17'(accel_z_offset_r);
        sg_r <= 17'(signed'(in_tdata[47:32])) + 17'(gyro_x_offset_r);
      end
      if (state_r == S_WB) begin
        case (op_r)
          OP_AY:  ay_r <= prod[ACC_W-1:0];
          OP_GX:  gx_r <= sat32((prod + (64'sd1 <<< (GYRO_SHIFT - 1))) >>> GYRO_SHIFT);
          OP_BT:  angle_r <= sat32(64'(angle_r) + 64'(gx_r) - prod_q);
          OP_PT:  pt_r <= sat32(prod_q);
          OP_CAA: cov_aa_r <= sat32(64'(cov_aa_r) + prod_q);
          OP_CBB: cov_bb_r <= sat32(64'(cov_bb_r) + prod_q);
          OP_UA:  angle_r <= sat32(64'(angle_r) + prod_q);
          OP_UB:  bias_r <= sat32(64'(bias_r) + prod_q);
          OP_UBA: cov_ba_r <= sat32(64'(cov_ba_r) - prod_q);
          OP_UBB: cov_bb_r <= sat32(64'(cov_bb_r) - prod_q);
          OP_UAA: cov_aa_r <= sat32(64'(cov_aa_r) - prod_q);
          OP_UAB: cov_ab_r <= sat32(64'(cov_ab_r) - prod_q);
          default: ;
        endcase
      end
      if (state_r == S_ALU) begin
        if (op_r == OP_PRE) begin
          tmp_r <= sat32(64'(pt_r) - 64'(cov_ab_r) - 64'(cov_ba_r) + Q_NOISE_ANGLE);
          cov_ab_r <= sat32(64'(cov_ab_r) - 64'(pt_r));
          cov_ba_r <= sat32(64'(cov_ba_r) - 64'(pt_r));
        end else if (cor_done) begin
          var_r <= sat32(64'(roll) - 64'(angle_r));
        end
      end
      if (state_r == S_DIVW && div_done) begin
        if (op_r == OP_K0) k0_r <= div_q;
        else               k1_r <= div_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {bias_r, angle_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

/* rtl/kre_mul.sv */
// ----------------------------------------------------------------------------
// kre_mul
// Shared signed 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module kre_mul import kre_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [63:0]      p,
  output logic signed [63:0]      p_q
);

  logic signed [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= 64'(a) * 64'(b);
    end
  end

  assign p   = p_r;
  assign p_q = qround(p_r);

endmodule

`default_nettype wire

/* rtl/kre_div.sv */
// ----------------------------------------------------------------------------
// kre_div
// Restoring divider for the Kalman gains: (num << FRAC_BITS) / den,
// truncated toward zero and saturated, zero when den is not positive.
// ----------------------------------------------------------------------------
`default_nettype none

module kre_div import kre_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [31:0]      num,
  input  wire logic signed [ANG_W-1:0] den,
  output logic                         done,
  output logic signed [31:0]           q
);

  logic [DVD_W-1:0]  dvd_r;
  logic [31:0]       den_r;
  logic [31:0]       rem_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              neg_r;
  logic              run_r;
  logic              fin_r;
  logic              done_r;
  logic signed [31:0] q_r;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        qbit;
  logic [31:0] mag;

  assign mag     = num[31] ? 32'(-num) : 32'(num);
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign qbit    = !rem_sub[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (den <= 0) begin
        q_r    <= '0;
        done_r <= 1'b1;
        run_r  <= 1'b0;
      end else begin
        neg_r <= num[31];
        dvd_r <= {mag, FRAC_BITS'(0)};
        den_r <= den[31:0];
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end
    end else if (run_r) begin
      rem_r <= qbit ? rem_sub[31:0] : rem_sh[31:0];
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DVD_W - 1)) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end else if (fin_r) begin
      fin_r  <= 1'b0;
      done_r <= 1'b1;
      if (neg_r) begin
        q_r <= (dvd_r > DVD_W'(64'h8000_0000)) ? 32'sh80000000 : 32'(-dvd_r[31:0]);
      end else begin
        q_r <= (dvd_r > DVD_W'(64'h7fff_ffff)) ? 32'sh7fffffff : dvd_r[31:0];
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

`default_nettype wire

/* rtl/kre_cordic.sv */
// ----------------------------------------------------------------------------
// kre_cordic
// Vectoring CORDIC atan2(y, x), one rotation per cycle, full-circle range.
// ----------------------------------------------------------------------------
`default_nettype none

module kre_cordic import kre_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [ACC_W-1:0] x_in,
  input  wire logic signed [ACC_W-1:0] y_in,
  output logic                         done,
  output logic signed [ANG_W-1:0]      angle
);

  logic signed [CRD_W-1:0] x_r, y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [ITER_W-1:0]       cnt_r;
  logic                    run_r;
  logic                    done_r;

  logic signed [CRD_W-1:0] xe, ye, dx, dy;
  logic signed [ANG_W-1:0] a;

  assign xe = CRD_W'(x_in);
  assign ye = CRD_W'(y_in);
  assign dx = y_r >>> cnt_r[4:0];
  assign dy = x_r >>> cnt_r[4:0];
  assign a  = atan_q(cnt_r[4:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r <= '0;
      if (x_in == '0 && y_in == '0) begin
        z_r    <= '0;
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end else begin
        run_r  <= 1'b1;
        done_r <= 1'b0;
        if (x_in < 0) begin
          // turn the vector into the right half plane
          if (y_in >= 0) begin
            x_r <= ye;
            y_r <= -xe;
            z_r <= HALF_PI_Q;
          end else begin
            x_r <= -ye;
            y_r <= xe;
            z_r <= -HALF_PI_Q;
          end
        end else begin
          x_r <= xe;
          y_r <= ye;
          z_r <= '0;
        end
      end
    end else if (run_r) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + a;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - a;
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == ITER_W'(ATAN_ITERATIONS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done  = done_r;
  assign angle = z_r;

endmodule

`default_nettype wire

/* rtl/kre_checker.sv */
// ----------------------------------------------------------------------------
// kre_checker
// Port-level checks of the roll estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kre_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // one sample in flight: no second word right after acceptance
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a sample is in flight");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write not taken");

endmodule

bind kalman_roll_estimator_unit kre_checker u_kre_checker (.*);

`default_nettype wire

/* tb/sv/kalman_roll_estimator_unit_tb.sv */
// ----------------------------------------------------------------------------
// kalman_roll_estimator_unit_tb
// Self-checking bench: raw IMU words go in under random idling and stalls,
// the roll/bias words that come out are compared against a fixed-point
// predictor of the filter, with calibration changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

class roll_scoreboard;
  // calibration copy
  longint ay_off, az_off, gx_off, a_scale, g_scale, period;
  // filter state copy
  longint ang, bias, paa, pab, pba, pbb;
  logic [63:0] pending[$];
  int mismatches;

  function new();
    ay_off = 0; az_off = 0; gx_off = 0;
    a_scale = 16384; g_scale = 1464900; period = 2684355;
    ang = 0; bias = 0; paa = 0; pab = 0; pba = 0; pbb = 0;
    mismatches = 0;
  endfunction

  static function longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function longint rnd_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  static function longint fmul(longint a, longint b);
    return rnd_shr(clip(a) * clip(b), kre_pkg::FRAC_BITS);
  endfunction

  static function longint kgain(longint num, longint s);
    if (s <= 0) return 0;
    return clip((clip(num) * kre_pkg::ONE_Q) / s);
  endfunction

  static function longint roll_atan2(longint y, longint x);
    longint z, t, a, dx, dy;
    int k;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = rnd_shr(kre_pkg::HALF_PI_Q30, kre_pkg::ATAN_SHIFT);
      end else begin
        x = -y; y = t; z = -rnd_shr(kre_pkg::HALF_PI_Q30, kre_pkg::ATAN_SHIFT);
      end
    end
    for (int i = 0; i < kre_pkg::ATAN_ITERATIONS; i++) begin
      k = i & 31;
      a = rnd_shr(kre_pkg::ATAN_TAB[k], kre_pkg::ATAN_SHIFT);
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x += dx; y -= dy; z += a;
      end else begin
        x -= dx; y += dy; z -= a;
      end
    end
    return z;
  endfunction

  function void set_reg(kre_pkg::reg_idx_t idx, logic [31:0] v);
    case (idx)
      kre_pkg::REG_ACCEL_Y_OFFSET: ay_off = longint'($signed(v[15:0]));
      kre_pkg::REG_ACCEL_Z_OFFSET: az_off = longint'($signed(v[15:0]));
      kre_pkg::REG_GYRO_X_OFFSET:  gx_off = longint'($signed(v[15:0]));
      kre_pkg::REG_ACCEL_SCALE:    a_scale = longint'(v[30:0]);
      kre_pkg::REG_GYRO_SCALE:     g_scale = longint'(v[30:0]);
      kre_pkg::REG_SAMPLE_PERIOD:  period = longint'(v[30:0]);
      default: ;
    endcase
  endfunction

  function void note_sample(logic [47:0] w);
    longint ay, az, gx, roll, pt, s, k0, k1, innov, aa, ab;
    longint qa, qb, rm;
    qa = kre_pkg::Q_NOISE_ANGLE;
    qb = kre_pkg::Q_NOISE_BIAS;
    rm = kre_pkg::Q_NOISE_MEAS;
    ay = (longint'($signed(w[15:0])) + ay_off) * a_scale;
    az = (longint'($signed(w[31:16])) + az_off) * a_scale;
    gx = clip(rnd_shr((longint'($signed(w[47:32])) + gx_off) * g_scale,
                      kre_pkg::GYRO_SHIFT));
    roll = roll_atan2(ay, az);
    ang = clip(ang + gx - fmul(bias, period));
    pt = clip(fmul(period, pbb));
    paa = clip(paa + fmul(period, clip(pt - pab - pba + qa)));
    pab = clip(pab - pt);
    pba = clip(pba - pt);
    pbb = clip(pbb + fmul(qb, period));
    s = paa + rm;
    k0 = kgain(paa, s);
    k1 = kgain(pba, s);
    innov = clip(roll - ang);
    ang = clip(ang + fmul(k0, innov));
    bias = clip(bias + fmul(k1, innov));
    aa = paa; ab = pab;
    pba = clip(pba - fmul(k1, aa));
    pbb = clip(pbb - fmul(k1, ab));
    paa = clip(aa - fmul(k0, aa));
    pab = clip(ab - fmul(k0, ab));
    pending.push_back({bias[31:0], ang[31:0]});
  endfunction

  function void check_result(logic [63:0] got);
    logic [63:0] exp_w;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    exp_w = pending.pop_front();
    if (got[31:0] !== exp_w[31:0] || got[63:32] !== exp_w[63:32]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: roll exp %h got %h, bias exp %h got %h",
                 exp_w[31:0], got[31:0], exp_w[63:32], got[63:32]);
    end
  endfunction
endclass

module kalman_roll_estimator_unit_tb;
  import kre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [47:0] in_tdata;
  logic [63:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  int send_idle_pct, recv_stall_pct;
  roll_scoreboard board;

  kalman_roll_estimator_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("kalman_roll_estimator_unit verification failed");
    $finish;
  end

  // receiver: random stall, check on acceptance
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // the block is busy long after acceptance, so one cycle with tvalid low
  // between words costs no throughput
  task automatic send_sample(logic [47:0] w);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    board.note_sample(w);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_val();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly typical samples: small tilt, gravity mostly on Z, small rate; else edge values
  function automatic logic [47:0] rand_sample();
    logic [15:0] ay, az, gx;
    if ($urandom_range(9) < 7) begin
      ay = 16'($signed($urandom_range(8000)) - 4000);
      az = 16'($signed($urandom_range(8000)) + 12384);
      gx = 16'($signed($urandom_range(2000)) - 1000);
    end else begin
      ay = edge_val(); az = edge_val(); gx = edge_val();
    end
    return {gx, az, ay};
  endfunction

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_ACCEL_Y_OFFSET; cfg_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, zero accel vector, each quadrant
    send_sample({16'h0000, 16'h0000, 16'h0000});
    send_sample({16'h7fff, 16'h7fff, 16'h7fff});
    send_sample({16'h8000, 16'h8000, 16'h8000});
    send_sample({16'h0000, 16'h8000, 16'h7fff});
    send_sample({16'h8000, 16'h8000, 16'h0001});
    send_sample({16'h7fff, 16'h4000, 16'h8000});
    send_sample({16'h1234, 16'h8000, 16'h0000});
    send_sample({16'h5555, 16'haaaa, 16'h5555});
    send_sample({16'haaaa, 16'h5555, 16'haaaa});
    drain();
    // extreme scales drive the state into saturation
    write_reg(REG_ACCEL_SCALE, 32'h7fffffff);
    write_reg(REG_GYRO_SCALE, 32'h7fffffff);
    write_reg(REG_SAMPLE_PERIOD, 32'h7fffffff);
    write_reg(REG_ACCEL_Y_OFFSET, 32'h00008000);
    write_reg(REG_ACCEL_Z_OFFSET, 32'hffff7fff);
    write_reg(REG_GYRO_X_OFFSET, 32'h12347fff);
    for (int i = 0; i < 8; i++) send_sample({16'h7fff, 16'h7fff, 16'h8000});
    for (int i = 0; i < 4; i++) send_sample({16'h8000, 16'h8000, 16'h7fff});
    drain();
    // zero scales and an ignored index
    write_reg(REG_ACCEL_SCALE, 32'h80000000);
    write_reg(REG_GYRO_SCALE, 32'h0);
    write_reg(REG_SAMPLE_PERIOD, 32'h0);
    write_reg(reg_idx_t'(3'd7), 32'hffffffff);
    send_sample({16'h1111, 16'h2222, 16'h3333});
    send_sample({16'h8000, 16'h7fff, 16'h8000});
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      set_idling(phase);
      write_reg(REG_ACCEL_Y_OFFSET, $urandom_range(1) ? 32'($urandom_range(400)) - 200
                                                      : $urandom);
      write_reg(REG_ACCEL_Z_OFFSET, $urandom_range(1) ? 32'($urandom_range(400)) - 200
                                                      : $urandom);
      write_reg(REG_GYRO_X_OFFSET, $urandom_range(1) ? 32'($urandom_range(100)) - 50
                                                     : $urandom);
      write_reg(REG_ACCEL_SCALE, (phase == 7) ? 32'h7fffffff
                                 : $urandom_range(1) ? 32'd16384 : $urandom);
      write_reg(REG_GYRO_SCALE, (phase == 6) ? 32'h0
                                : $urandom_range(1) ? 32'd1464900 : $urandom);
      write_reg(REG_SAMPLE_PERIOD, (phase == 5) ? 32'h7fffffff
                                   : $urandom_range(1) ? 32'd2684355 : $urandom);
      for (int i = 0; i < 150; i++) send_sample(rand_sample());
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("kalman_roll_estimator_unit verification clean");
    end else begin
      $display("kalman_roll_estimator_unit verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* files.f */
rtl/kre_pkg.sv
rtl/kre_mul.sv
rtl/kre_div.sv
rtl/kre_cordic.sv
rtl/kalman_roll_estimator_unit.sv
rtl/kre_checker.sv
tb/sv/kalman_roll_estimator_unit_tb.sv
